[rtl/core/m3inv_pkg.sv]
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared widths, types and constants of the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  localparam int unsigned M3INV_FRAC_BITS = 16;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ELEM_N = 9;
  localparam int unsigned ROW_N  = 3;
  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned ADJ_W  = PROD_W;
  // three terms of at most 2^94 each
  localparam int unsigned DET_W  = 97;
  localparam int unsigned DMAG_W = DET_W - 1;
  // divisor is twice the determinant magnitude
  localparam int unsigned DIV_W  = DMAG_W + 1;
  localparam int unsigned QUO_W  = DATA_W;
  localparam int unsigned REM_W  = DIV_W + 1;

  localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;
  localparam logic [ELEM_N-1:0] DIAG_MASK = 9'b1_0001_0001;

  typedef logic signed [DATA_W-1:0] m3inv_elem_t;
  typedef logic [3:0]               m3inv_idx_t;

  // adjugate element k = m[A]*m[B] - m[C]*m[D]
  localparam m3inv_idx_t ADJ_A [ELEM_N] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam m3inv_idx_t ADJ_B [ELEM_N] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam m3inv_idx_t ADJ_C [ELEM_N] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam m3inv_idx_t ADJ_D [ELEM_N] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  // per-lane sign of the quotient and the zero-determinant mark
  typedef struct packed {
    logic [ELEM_N-1:0] neg;
    logic              singular;
  } m3inv_tag_t;

  typedef struct packed {
    logic [ELEM_N-1:0][DATA_W-1:0] r;
    logic                          singular;
    logic                          overflow;
  } m3inv_res_t;

  // width of 2*|adj|*2^(2F) + |det|
  function automatic int unsigned m3inv_num_w(input int unsigned frac);
    int unsigned w;
    w = ADJ_W + 2 * frac + 1;
    if (w < DMAG_W) begin
      w = DMAG_W;
    end
    return w + 1;
  endfunction

endpackage

[rtl/core/m3inv_if.sv]
// ----------------------------------------------------------------------------
// m3inv_if
// Valid/ready channels of the 3x3 matrix inverse core: matrix in, inverse out.
// ----------------------------------------------------------------------------
interface m3inv_in_if import m3inv_pkg::*; ();
  logic        valid;
  logic        ready;
  m3inv_elem_t a00, a01, a02;
  m3inv_elem_t a10, a11, a12;
  m3inv_elem_t a20, a21, a22;

  modport source (
    output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
    input  ready
  );
  modport sink (
    input  valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
    output ready
  );
endinterface

interface m3inv_out_if import m3inv_pkg::*; ();
  logic        valid;
  logic        ready;
  m3inv_elem_t r00, r01, r02;
  m3inv_elem_t r10, r11, r12;
  m3inv_elem_t r20, r21, r22;
  logic        singular;
  logic        overflow;

  modport source (
    output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, overflow,
    input  ready
  );
  modport sink (
    input  valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, singular, overflow,
    output ready
  );
endinterface

[rtl/core/m3inv_div.sv]
// ----------------------------------------------------------------------------
// m3inv_div
// Nine-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module m3inv_div import m3inv_pkg::*; #(
  parameter int unsigned FRAC_BITS = M3INV_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_v,
  input  logic [m3inv_num_w(FRAC_BITS)-1:0]   num [ELEM_N],
  input  logic [DIV_W-1:0]                    dv,
  input  m3inv_tag_t                          tag_in,
  output logic                                out_v,
  output logic [QUO_W-1:0]                    q [ELEM_N],
  output logic [ELEM_N-1:0]                   ovf,
  output m3inv_tag_t                          tag_out
);

  localparam int unsigned NUM_W  = m3inv_num_w(FRAC_BITS);
  localparam int unsigned HI_W   = NUM_W - QUO_W;
  localparam int unsigned CMP_W  = (HI_W > DIV_W) ? HI_W : DIV_W;
  localparam int unsigned STEP_N = QUO_W;

  logic [STEP_N:0]   v_r;
  m3inv_tag_t        tag_r [STEP_N+1];
  logic [ELEM_N-1:0] ovf_r [STEP_N+1];
  logic [DIV_W-1:0]  dv_r  [STEP_N+1];
  logic [REM_W-1:0]  rem_r [STEP_N+1][ELEM_N];
  logic [QUO_W-1:0]  lo_r  [STEP_N+1][ELEM_N];
  logic [QUO_W-1:0]  q_r   [STEP_N+1][ELEM_N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[STEP_N-1:0], in_v};
    end
  end

  // quotient of 2^32 or more saturates; otherwise the high part is below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      tag_r[0] <= tag_in;
      dv_r[0]  <= dv;
      for (int k = 0; k < ELEM_N; k++) begin
        ovf_r[0][k] <= CMP_W'(num[k][NUM_W-1:QUO_W]) >= CMP_W'(dv);
        rem_r[0][k] <= REM_W'(num[k][NUM_W-1:QUO_W]);
        lo_r[0][k]  <= num[k][QUO_W-1:0];
        q_r[0][k]   <= '0;
      end
    end
  end

  for (genvar s = 1; s <= STEP_N; s++) begin : g_step
    for (genvar k = 0; k < ELEM_N; k++) begin : g_lane
      logic [REM_W-1:0] sh;
      logic [REM_W:0]   diff;

      assign sh   = {rem_r[s-1][k][REM_W-2:0], lo_r[s-1][k][QUO_W-1]};
      assign diff = {1'b0, sh} - (REM_W+1)'(dv_r[s-1]);

      // keep the remainder on borrow, else take the difference
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s][k] <= diff[REM_W] ? sh : diff[REM_W-1:0];
          q_r[s][k]   <= {q_r[s-1][k][QUO_W-2:0], !diff[REM_W]};
          lo_r[s][k]  <= {lo_r[s-1][k][QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[s] <= tag_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        dv_r[s]  <= dv_r[s-1];
      end
    end
  end

  assign out_v   = v_r[STEP_N];
  assign q       = q_r[STEP_N];
  assign ovf     = ovf_r[STEP_N];
  assign tag_out = tag_r[STEP_N];

endmodule

[rtl/core/matrix3_inverse_core.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse_core
// Inverse of a 3x3 signed fixed-point matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake          | word
//  ----------+-----+--------------------+---------------------------------------
//  in_ch     | in  | valid / ready      | a00..a22, signed Q(31-F).F each
//  out_ch    | out | valid / ready      | r00..r22 signed, singular, overflow
//
//  One word enters per clock while nothing stalls; a result word passes through
//  9 front stages, 33 divider stages and the output register. The divider's
//  32 quotient-bit stages make up most of that depth.
//  Reset (rst_n low, synchronous) drops every word in flight.
//  A stall on out_ch fills a one-word skid behind the output register; only a
//  full skid freezes the pipeline and drops in_ch.ready, so input is still
//  taken while a finished word waits.
//
module matrix3_inverse_core import m3inv_pkg::*; #(
  parameter int unsigned FRAC_BITS = M3INV_FRAC_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  m3inv_in_if.sink     in_ch,
  m3inv_out_if.source  out_ch
);

  localparam int unsigned NUM_W   = m3inv_num_w(FRAC_BITS);
  localparam int unsigned SHIFT   = 2 * FRAC_BITS + 1;
  localparam int unsigned STG_N   = 9;
  localparam int unsigned CARRY_N = 5;
  localparam logic [DATA_W-1:0] UNIT_VAL = DATA_W'(1) << FRAC_BITS;

  // pipeline advance: everything moves unless the skid holds a word
  logic en;
  logic skid_v_r;
  logic out_v_r;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  logic [STG_N-1:0] stg_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= '0;
    end else if (en) begin
      stg_v_r <= {stg_v_r[STG_N-2:0], in_ch.valid};
    end
  end

  // ---------------- front stages ----------------
  m3inv_elem_t               in_elem [ELEM_N];
  m3inv_elem_t               m_r     [ELEM_N];     // S0: input matrix
  logic signed [PROD_W-1:0]  pa_r    [ELEM_N];     // S1: minor products
  logic signed [PROD_W-1:0]  pc_r    [ELEM_N];
  m3inv_elem_t               r0_r    [2][ROW_N];   // row 0, held for the det
  logic signed [ADJ_W-1:0]   adj_r   [ELEM_N];     // S2: adjugate
  logic signed [PROD_W:0]    pl_r    [ROW_N];      // S3: det partial products
  logic signed [PROD_W-1:0]  ph_r    [ROW_N];
  logic [ADJ_W-1:0]          amag_r  [CARRY_N][ELEM_N];
  logic [ELEM_N-1:0]         aneg_r  [CARRY_N];
  logic signed [DET_W-1:0]   t_r     [ROW_N];      // S4: det terms
  logic signed [DET_W-1:0]   s_r;                  // S5: partial sum
  logic signed [DET_W-1:0]   t2_r;
  logic signed [DET_W-1:0]   det_r;                // S6: determinant
  logic [DMAG_W-1:0]         dmag_r;               // S7: |det|, sign, zero
  logic                      dneg_r;
  logic                      dzero_r;
  logic [NUM_W-1:0]          num_r   [ELEM_N];     // S8: dividends
  logic [DIV_W-1:0]          dv_r;
  m3inv_tag_t                tag8_r;

  always_comb begin
    in_elem[0] = in_ch.a00;
    in_elem[1] = in_ch.a01;
    in_elem[2] = in_ch.a02;
    in_elem[3] = in_ch.a10;
    in_elem[4] = in_ch.a11;
    in_elem[5] = in_ch.a12;
    in_elem[6] = in_ch.a20;
    in_elem[7] = in_ch.a21;
    in_elem[8] = in_ch.a22;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // S0: register the matrix
      m_r <= in_elem;

      // S1: two 32x32 products per cofactor
      for (int k = 0; k < ELEM_N; k++) begin
        pa_r[k] <= m_r[ADJ_A[k]] * m_r[ADJ_B[k]];
        pc_r[k] <= m_r[ADJ_C[k]] * m_r[ADJ_D[k]];
      end
      for (int j = 0; j < ROW_N; j++) begin
        r0_r[0][j] <= m_r[j];
      end

      // S2: cofactor differences, signs already folded into the operand order
      for (int k = 0; k < ELEM_N; k++) begin
        adj_r[k] <= pa_r[k] - pc_r[k];
      end
      r0_r[1] <= r0_r[0];

      // S3: split the three row-0 cofactors into halves for 32x32 multipliers
      for (int j = 0; j < ROW_N; j++) begin
        pl_r[j] <= r0_r[1][j] * $signed({1'b0, adj_r[ROW_N*j][DATA_W-1:0]});
        ph_r[j] <= r0_r[1][j] * $signed(adj_r[ROW_N*j][ADJ_W-1:DATA_W]);
      end
      for (int k = 0; k < ELEM_N; k++) begin
        amag_r[0][k] <= adj_r[k][ADJ_W-1] ? -adj_r[k] : adj_r[k];
        aneg_r[0][k] <= adj_r[k][ADJ_W-1];
      end
      for (int s = 1; s < CARRY_N; s++) begin
        amag_r[s] <= amag_r[s-1];
        aneg_r[s] <= aneg_r[s-1];
      end

      // S4: recombine halves
      for (int j = 0; j < ROW_N; j++) begin
        t_r[j] <= (DET_W'(ph_r[j]) <<< DATA_W) + DET_W'(pl_r[j]);
      end

      // S5, S6: sum the three terms
      s_r   <= t_r[0] + t_r[1];
      t2_r  <= t_r[2];
      det_r <= s_r + t2_r;

      // S7: magnitude and sign of the determinant
      dneg_r  <= det_r[DET_W-1];
      dmag_r  <= DMAG_W'(det_r[DET_W-1] ? -det_r : det_r);
      dzero_r <= (det_r == '0);

      // S8: round to nearest by dividing (2*adj*2^2F + d) by 2d
      for (int k = 0; k < ELEM_N; k++) begin
        num_r[k] <= (NUM_W'(amag_r[CARRY_N-1][k]) << SHIFT) + NUM_W'(dmag_r);
      end
      dv_r            <= {dmag_r, 1'b0};
      tag8_r.neg      <= aneg_r[CARRY_N-1] ^ {ELEM_N{dneg_r}};
      tag8_r.singular <= dzero_r;
    end
  end

  // ---------------- divider ----------------
  logic              div_v;
  logic [QUO_W-1:0]  div_q [ELEM_N];
  logic [ELEM_N-1:0] div_ovf;
  m3inv_tag_t        div_tag;

  m3inv_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (stg_v_r[STG_N-1]),
    .num     (num_r),
    .dv      (dv_r),
    .tag_in  (tag8_r),
    .out_v   (div_v),
    .q       (div_q),
    .ovf     (div_ovf),
    .tag_out (div_tag)
  );

  // ---------------- sign, saturation, identity ----------------
  m3inv_res_t        fin;
  logic [ELEM_N-1:0] lane_sat;

  always_comb begin
    lane_sat     = '0;
    fin.singular = div_tag.singular;
    for (int k = 0; k < ELEM_N; k++) begin
      if (div_tag.singular) begin
        fin.r[k] = DIAG_MASK[k] ? UNIT_VAL : '0;
      end else if (div_tag.neg[k]) begin
        // magnitude of exactly 2^31 still fits as the most negative value
        lane_sat[k] = div_ovf[k] || (div_q[k] > NEG_LIMIT);
        fin.r[k]    = lane_sat[k] ? NEG_LIMIT : (~div_q[k] + 1'b1);
      end else begin
        lane_sat[k] = div_ovf[k] || div_q[k][QUO_W-1];
        fin.r[k]    = lane_sat[k] ? POS_LIMIT : div_q[k];
      end
    end
    fin.overflow = !div_tag.singular && (|lane_sat);
  end

  // ---------------- output register and skid ----------------
  m3inv_res_t out_r;
  m3inv_res_t skid_r;
  logic       fin_take;

  assign fin_take = div_v && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      // output slot free: drain the skid first, else take the divider word
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r <= fin_take;
      end
    end else if (fin_take) begin
      // output held: park the arriving word
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ch.ready) begin
      out_r <= skid_v_r ? skid_r : fin;
    end else if (fin_take) begin
      skid_r <= fin;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.r00      = out_r.r[0];
  assign out_ch.r01      = out_r.r[1];
  assign out_ch.r02      = out_r.r[2];
  assign out_ch.r10      = out_r.r[3];
  assign out_ch.r11      = out_r.r[4];
  assign out_ch.r12      = out_r.r[5];
  assign out_ch.r20      = out_r.r[6];
  assign out_ch.r21      = out_r.r[7];
  assign out_ch.r22      = out_r.r[8];
  assign out_ch.singular = out_r.singular;
  assign out_ch.overflow = out_r.overflow;

  // ---------------- checks ----------------
  logic lim_seen;

  always_comb begin
    lim_seen = 1'b0;
    for (int k = 0; k < ELEM_N; k++) begin
      if ((out_r.r[k] == POS_LIMIT) || (out_r.r[k] == NEG_LIMIT)) begin
        lim_seen = 1'b1;
      end
    end
  end

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while the output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !out_ch.ready |=> skid_v_r && $stable(skid_r))
    else $error("skid word lost or changed during an output stall");

  a_singular_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.singular |->
      !out_r.overflow && (out_r.r[0] == UNIT_VAL) && (out_r.r[1] == '0))
    else $error("singular result is not the identity");

  a_overflow_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.overflow |-> lim_seen)
    else $error("overflow flagged without a saturated element");

endmodule
